// File: sv/idt_pkg.sv
// ----------------------------------------------------------------------------
// idt_pkg: shared types and constants of the indent/dedent tracker
// Widths of the indent levels, stack depth, result kinds and the control
// word that steps the row of stack cells.
// ----------------------------------------------------------------------------
package idt_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int WIDTH_BITS  = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int CP_W    = 21;
  localparam int KIND_W  = 3;
  localparam int LEVEL_W = 16;
  localparam int TAB_W   = 5;

  localparam logic [TAB_W-1:0] TAB_RESET = TAB_W'(8);

  localparam logic [CP_W-1:0] CP_SPACE = CP_W'(8'h20);
  localparam logic [CP_W-1:0] CP_TAB   = CP_W'(8'h09);
  localparam logic [CP_W-1:0] CP_HASH  = CP_W'(8'h23);
  localparam logic [CP_W-1:0] CP_LF    = CP_W'(8'h0A);
  localparam logic [CP_W-1:0] CP_CR    = CP_W'(8'h0D);

  localparam logic [KIND_W-1:0] KIND_WS        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SAME      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BLANK     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INDENT    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEDENT    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_UNMATCHED = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd6;
  localparam logic [KIND_W-1:0] KIND_NOTHING   = 3'd7;

  // Step command for the stack row: push shifts every level one cell
  // deeper, pop shifts every level one cell towards the top.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

endpackage

// File: sv/idt_if.sv
// ----------------------------------------------------------------------------
// idt_in_if / idt_out_if: valid/ready channels of the indent/dedent tracker
// The input channel carries one leading character per transfer, the output
// channel one result per transfer.
// ----------------------------------------------------------------------------
interface idt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [idt_pkg::CP_W-1:0]     code_point;
  logic                         following_is_newline;
  logic                         in_group;
  logic                         first_of_line;

  modport source (
    output valid, mode, code_point, following_is_newline, in_group, first_of_line,
    input  ready
  );
  modport sink (
    input  valid, mode, code_point, following_is_newline, in_group, first_of_line,
    output ready
  );
endinterface

interface idt_out_if;
  logic                          valid;
  logic                          ready;
  logic [idt_pkg::KIND_W-1:0]    kind;
  logic                          last;
  logic [idt_pkg::LEVEL_W-1:0]   level;

  modport source (
    output valid, kind, last, level,
    input  ready
  );
  modport sink (
    input  valid, kind, last, level,
    output ready
  );
endinterface

// File: sv/idt_cell.sv
// ----------------------------------------------------------------------------
// idt_cell: one entry of the indent level stack
// Holds one level, takes its upper neighbour's level on a push and its
// lower neighbour's level on a pop, and flags a match against the width.
// ----------------------------------------------------------------------------
module idt_cell (
  input  logic                             clk_i,
  input  idt_pkg::stk_ctrl_t               ctrl_i,
  input  logic [idt_pkg::WIDTH_BITS-1:0]   upper_i,
  input  logic [idt_pkg::WIDTH_BITS-1:0]   lower_i,
  input  logic                             occ_i,
  input  logic [idt_pkg::WIDTH_BITS-1:0]   cmp_i,
  output logic [idt_pkg::WIDTH_BITS-1:0]   level_o,
  output logic                             match_o
);

  logic [idt_pkg::WIDTH_BITS-1:0] level_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      level_q <= upper_i;
    end else if (ctrl_i.pop) begin
      level_q <= lower_i;
    end
  end

  assign level_o = level_q;
  assign match_o = occ_i && (level_q == cmp_i);

endmodule

// File: sv/idt_stack.sv
// ----------------------------------------------------------------------------
// idt_stack: row of cells forming the indent level stack
// Cell 0 is always the top of the stack; levels move one cell per step.
// All occupied cells compare against the line width at once.
// ----------------------------------------------------------------------------
module idt_stack (
  input  logic                             clk_i,
  input  idt_pkg::stk_ctrl_t               ctrl_i,
  input  logic [idt_pkg::WIDTH_BITS-1:0]   push_level_i,
  input  logic [idt_pkg::CNT_W-1:0]        count_i,
  input  logic [idt_pkg::WIDTH_BITS-1:0]   cmp_i,
  output logic [idt_pkg::WIDTH_BITS-1:0]   top_o,
  output logic [idt_pkg::WIDTH_BITS-1:0]   next_o,
  output logic                             found_o
);

  logic [idt_pkg::WIDTH_BITS-1:0] level [idt_pkg::STACK_DEPTH];
  logic [idt_pkg::STACK_DEPTH-1:0] match;

  for (genvar k = 0; k < idt_pkg::STACK_DEPTH; k++) begin : g_cell
    logic [idt_pkg::WIDTH_BITS-1:0] upper;
    logic [idt_pkg::WIDTH_BITS-1:0] lower;
    logic                           occ;

    if (k == 0) begin : g_top
      assign upper = push_level_i;
    end else begin : g_mid
      assign upper = level[k-1];
    end

    // The deepest cell keeps its own value on a pop; it is then unoccupied.
    if (k == idt_pkg::STACK_DEPTH - 1) begin : g_bottom
      assign lower = level[k];
    end else begin : g_inner
      assign lower = level[k+1];
    end

    assign occ = count_i > idt_pkg::CNT_W'(k);

    idt_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .upper_i (upper),
      .lower_i (lower),
      .occ_i   (occ),
      .cmp_i   (cmp_i),
      .level_o (level[k]),
      .match_o (match[k])
    );
  end

  assign top_o   = level[0];
  assign next_o  = level[1];
  assign found_o = |match;

endmodule

// File: sv/indent_dedent_tracker.sv
// ----------------------------------------------------------------------------
// indent_dedent_tracker: indentation tracker with INDENT/DEDENT results
// Tracks the indent width of each source line and a stack of indent levels.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries one leading character of a line, or an
// end-of-input marker (mode = 1). Spaces and tabs are absorbed into the line
// width; the first other character settles the line. Each input gives one
// or more results on the output channel; the final one has last set.
// A single-result item is in the output register in the cycle after it is
// taken. A shallower line with a non-zero width first compares every stack
// cell against the width, then gives one DEDENT per cycle while the output
// is free, or UNMATCHED if no cell matches; a dedent to zero, or end of
// input on a non-empty stack, gives one DEDENT per cycle from the start. The
// rate is set by the single output register and by the stack row, which
// moves one level per cycle. No new item is taken while a burst of DEDENT
// results is being produced. A stalled receiver holds the output register;
// the block waits with it. tab_width is to be written through
// cfg_we_i/cfg_wdata_i only while the block is idle; it does not enforce it.
// After reset the stack is empty, no line is scanned and tab_width is 8.
// ----------------------------------------------------------------------------
module indent_dedent_tracker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [idt_pkg::TAB_W-1:0]    cfg_wdata_i,
  idt_in_if.sink                       in_i,
  idt_out_if.source                    out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;

  localparam int WB = idt_pkg::WIDTH_BITS;

  logic [1:0]                       state_q, state_d;
  logic [idt_pkg::TAB_W-1:0]        tab_q;
  logic [idt_pkg::CNT_W-1:0]        count_q, count_d;
  logic [WB-1:0]                    width_q, width_d;
  logic                             scan_q, scan_d;
  logic                             pop_all_q, pop_all_d;

  logic                             out_valid_q, out_valid_d;
  logic [idt_pkg::KIND_W-1:0]       kind_q, kind_d;
  logic                             last_q, last_d;
  logic [idt_pkg::LEVEL_W-1:0]      level_q, level_d;
  logic                             emit;

  idt_pkg::stk_ctrl_t               stk_ctrl;
  logic [WB-1:0]                    top_lvl, next_lvl, cur, eff;
  logic                             found, out_free, accept;
  logic [WB:0]                      sum;
  logic [idt_pkg::TAB_W-1:0]        add;
  logic                             is_ws, is_blank, pop_last;

  idt_stack u_stack (
    .clk_i        (clk_i),
    .ctrl_i       (stk_ctrl),
    .push_level_i (eff),
    .count_i      (count_q),
    .cmp_i        (width_q),
    .top_o        (top_lvl),
    .next_o       (next_lvl),
    .found_o      (found)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept = in_i.valid && in_i.ready;

  assign cur = (count_q == '0) ? '0 : top_lvl;
  assign eff = in_i.first_of_line ? '0 : width_q;

  assign is_ws = (in_i.code_point == idt_pkg::CP_SPACE) ||
                 (in_i.code_point == idt_pkg::CP_TAB);
  assign is_blank = (in_i.code_point == idt_pkg::CP_LF) ||
                    ((in_i.code_point == idt_pkg::CP_CR) && in_i.following_is_newline);
  assign add = (in_i.code_point == idt_pkg::CP_SPACE) ? idt_pkg::TAB_W'(1) : tab_q;
  assign sum = {1'b0, eff} + (WB+1)'(add);

  // The popped level is the last of the burst when the level below it is
  // the target: the bottom of the stack, or the matching width.
  assign pop_last = pop_all_q ? (count_q == idt_pkg::CNT_W'(1))
                              : ((count_q > idt_pkg::CNT_W'(1)) && (next_lvl == width_q));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    width_d   = width_q;
    scan_d    = scan_q;
    pop_all_d = pop_all_q;
    stk_ctrl  = '0;
    emit      = 1'b0;
    kind_d    = kind_q;
    last_d    = 1'b1;
    level_d   = idt_pkg::LEVEL_W'(cur);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          if (in_i.mode) begin
            scan_d    = 1'b0;
            width_d   = '0;
            pop_all_d = 1'b1;
            if (count_q == '0) begin
              kind_d = idt_pkg::KIND_NOTHING;
            end else begin
              emit    = 1'b0;
              state_d = ST_POP;
            end
          end else if (!(in_i.first_of_line || scan_q)) begin
            kind_d = idt_pkg::KIND_NOTHING;
          end else if (is_ws) begin
            scan_d  = 1'b1;
            width_d = sum[WB] ? '1 : sum[WB-1:0];
            kind_d  = idt_pkg::KIND_WS;
          end else begin
            scan_d  = 1'b0;
            width_d = eff;
            if (in_i.in_group || (in_i.code_point == idt_pkg::CP_HASH)) begin
              kind_d = idt_pkg::KIND_SAME;
            end else if (is_blank) begin
              kind_d = idt_pkg::KIND_BLANK;
            end else if (eff == cur) begin
              kind_d = idt_pkg::KIND_SAME;
            end else if (eff > cur) begin
              if (count_q == idt_pkg::CNT_W'(idt_pkg::STACK_DEPTH)) begin
                kind_d = idt_pkg::KIND_FULL;
              end else begin
                stk_ctrl.push = 1'b1;
                count_d       = count_q + idt_pkg::CNT_W'(1);
                kind_d        = idt_pkg::KIND_INDENT;
                level_d       = idt_pkg::LEVEL_W'(eff);
              end
            end else if (eff == '0) begin
              emit      = 1'b0;
              pop_all_d = 1'b1;
              state_d   = ST_POP;
            end else begin
              emit      = 1'b0;
              pop_all_d = 1'b0;
              state_d   = ST_SRCH;
            end
          end
        end
      end

      ST_SRCH: begin
        if (out_free) begin
          if (found) begin
            state_d = ST_POP;
          end else begin
            emit    = 1'b1;
            kind_d  = idt_pkg::KIND_UNMATCHED;
            state_d = ST_IDLE;
          end
        end
      end

      ST_POP: begin
        if (out_free) begin
          emit         = 1'b1;
          stk_ctrl.pop = 1'b1;
          count_d      = count_q - idt_pkg::CNT_W'(1);
          kind_d       = idt_pkg::KIND_DEDENT;
          last_d       = pop_last;
          level_d      = (count_q > idt_pkg::CNT_W'(1)) ? idt_pkg::LEVEL_W'(next_lvl) : '0;
          if (pop_last) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tab_q       <= idt_pkg::TAB_RESET;
      count_q     <= '0;
      width_q     <= '0;
      scan_q      <= 1'b0;
      pop_all_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      width_q     <= width_d;
      scan_q      <= scan_d;
      pop_all_q   <= pop_all_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tab_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q  <= kind_d;
      last_q  <= last_d;
      level_q <= level_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.kind  = kind_q;
  assign out_o.last  = last_q;
  assign out_o.level = level_q;

endmodule
